>>> design/srpd_pkg.sv
// Package for the sensor reply parser: widths, status codes, header bytes and reset values.
// It has no dependencies. The parser and the top level both use it.
`timescale 1ns / 1ps
`default_nettype none

package srpd_pkg;

  localparam int unsigned ReadingWidth     = 47;
  localparam int unsigned GainWidth        = 32;
  localparam int unsigned DacWidth         = 12;
  localparam int unsigned HeaderLen        = 6;
  localparam int unsigned SpaceSearchEndDefault = 19;
  localparam logic [GainWidth-1:0] DacGainReset = 32'd3477526;
  localparam logic [DacWidth-1:0]  DacMax       = 12'd4095;
  localparam logic [7:0]           CharSpace    = 8'h20;
  localparam logic [7:0]           CharMinus    = 8'h2d;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_HEADER = 3'd1,
    STATUS_NEGATIVE   = 3'd2,
    STATUS_NO_SPACE   = 3'd3,
    STATUS_NON_DIGIT  = 3'd4
  } status_e;

  typedef struct packed {
    status_e                 status;
    logic [ReadingWidth-1:0] reading;
  } parse_result_t;

  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h23;
      3'd1: b = 8'h4d;
      3'd2: b = 8'h4f;
      3'd3: b = 8'h58;
      3'd4: b = 8'h59;
      3'd5: b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/srpd_parser.sv
// Byte-wise parser for one sensor reply: header check, sign check, space search and digits.
// Depends on srpd_pkg. Its state clears when the end transaction is taken.
`timescale 1ns / 1ps
`default_nettype none

module srpd_parser #(
  parameter int unsigned SPACE_SEARCH_END = srpd_pkg::SpaceSearchEndDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  byte_en_i,
  input  wire logic                  end_en_i,
  input  wire logic [7:0]            rx_byte_i,
  output srpd_pkg::parse_result_t    result_o
);

  localparam int unsigned PosLimit = SPACE_SEARCH_END + 2;
  localparam int unsigned PosWidth = $clog2(PosLimit + 1);
  localparam int unsigned AccWidth = srpd_pkg::ReadingWidth;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [AccWidth-1:0] acc_q, acc_d;
  logic space_q, space_d;
  logic header_bad_q, header_bad_d;
  logic sign_bad_q, sign_bad_d;
  logic digit_bad_q, digit_bad_d;

  logic in_header;
  logic in_window;
  logic is_digit;
  logic [AccWidth-1:0] acc_times_ten;

  assign in_header     = pos_q < PosWidth'(srpd_pkg::HeaderLen);
  assign in_window     = !in_header && !space_q && (pos_q < PosWidth'(PosLimit));
  assign is_digit      = rx_byte_i inside {[8'h30:8'h39]};
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1);

  always_comb begin
    pos_d        = pos_q;
    acc_d        = acc_q;
    space_d      = space_q;
    header_bad_d = header_bad_q;
    sign_bad_d   = sign_bad_q;
    digit_bad_d  = digit_bad_q;
    if (end_en_i) begin
      pos_d        = '0;
      acc_d        = '0;
      space_d      = 1'b0;
      header_bad_d = 1'b0;
      sign_bad_d   = 1'b0;
      digit_bad_d  = 1'b0;
    end else if (byte_en_i) begin
      if (in_header) begin
        if (rx_byte_i != srpd_pkg::header_byte(pos_q[2:0])) begin
          header_bad_d = 1'b1;
        end
      end else if (in_window) begin
        if (pos_q == PosWidth'(srpd_pkg::HeaderLen) && rx_byte_i == srpd_pkg::CharMinus) begin
          sign_bad_d = 1'b1;
        end
        if (rx_byte_i == srpd_pkg::CharSpace) begin
          space_d = 1'b1;
        end else if (is_digit) begin
          acc_d = acc_times_ten + AccWidth'(rx_byte_i[3:0]);
        end else begin
          digit_bad_d = 1'b1;
        end
      end
      if (pos_q < PosWidth'(PosLimit)) begin
        pos_d = pos_q + PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      acc_q        <= '0;
      space_q      <= 1'b0;
      header_bad_q <= 1'b0;
      sign_bad_q   <= 1'b0;
      digit_bad_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      acc_q        <= acc_d;
      space_q      <= space_d;
      header_bad_q <= header_bad_d;
      sign_bad_q   <= sign_bad_d;
      digit_bad_q  <= digit_bad_d;
    end
  end

  always_comb begin
    if (header_bad_q || in_header) begin
      result_o.status = srpd_pkg::STATUS_BAD_HEADER;
    end else if (sign_bad_q) begin
      result_o.status = srpd_pkg::STATUS_NEGATIVE;
    end else if (!space_q) begin
      result_o.status = srpd_pkg::STATUS_NO_SPACE;
    end else if (digit_bad_q) begin
      result_o.status = srpd_pkg::STATUS_NON_DIGIT;
    end else begin
      result_o.status = srpd_pkg::STATUS_OK;
    end
    result_o.reading = (result_o.status == srpd_pkg::STATUS_OK) ? acc_q : '0;
  end

endmodule

`default_nettype wire

>>> design/sensor_reply_parser_to_dac_top.sv
// Top level of the sensor reply parser with DAC scaling: parser, multiply stage and output stage.
// Depends on srpd_pkg and srpd_parser.
//
//   Channel   Handshake                 Payload
//   input     in_valid_i / in_ready_o   kind_i, rx_byte_i
//   output    out_valid_o / out_ready_i status_o, reading_o, dac_code_o, dac_saturated_o
//   config    dac_gain_we_i             dac_gain_i
//
// One transaction is taken per cycle while in_ready_o is high. An end transaction's two partial
// products of reading and gain are registered, then their sum and the clamp in the output stage.
// Reset clears the parse state, the held DAC code and both stage valid flags, and loads the
// default gain.
// A stalled output holds the pipeline, and input ready drops only when both stages are full
// and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module sensor_reply_parser_to_dac_top #(
  parameter int unsigned SPACE_SEARCH_END = srpd_pkg::SpaceSearchEndDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 kind_i,
  input  wire logic [7:0]                           rx_byte_i,
  input  wire logic                                 dac_gain_we_i,
  input  wire logic [srpd_pkg::GainWidth-1:0]       dac_gain_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [2:0]                                status_o,
  output logic [srpd_pkg::ReadingWidth-1:0]         reading_o,
  output logic [srpd_pkg::DacWidth-1:0]             dac_code_o,
  output logic                                      dac_saturated_o
);

  localparam int unsigned RW = srpd_pkg::ReadingWidth;
  localparam int unsigned GW = srpd_pkg::GainWidth;
  localparam int unsigned DW = srpd_pkg::DacWidth;
  localparam int unsigned HiW = RW - GW;

  logic in_accept, byte_en, end_en;
  logic mid_adv, out_adv;
  srpd_pkg::parse_result_t parse_res;

  logic [GW-1:0] gain_q;
  logic [DW-1:0] last_code_q;

  logic mid_valid_q;
  srpd_pkg::status_e mid_status_q;
  logic [RW-1:0] mid_reading_q;
  logic [HiW+GW-1:0] prod_hi_q;
  logic [GW-1:0] prod_lo_q;
  logic [2*GW-1:0] prod_lo_full;

  logic out_valid_q;
  srpd_pkg::status_e out_status_q;
  logic [RW-1:0] out_reading_q;
  logic [DW-1:0] out_code_q;
  logic out_sat_q;

  logic [RW:0] scaled;
  logic over;
  logic mid_ok;
  logic [DW-1:0] new_code;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign mid_adv    = !mid_valid_q || out_adv;
  assign in_ready_o = mid_adv;
  assign in_accept  = in_valid_i && in_ready_o;
  assign byte_en    = in_accept && !kind_i;
  assign end_en     = in_accept && kind_i;

  srpd_parser #(
    .SPACE_SEARCH_END(SPACE_SEARCH_END)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (byte_en),
    .end_en_i  (end_en),
    .rx_byte_i (rx_byte_i),
    .result_o  (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= srpd_pkg::DacGainReset;
    end else if (dac_gain_we_i) begin
      gain_q <= dac_gain_i;
    end
  end

  assign prod_lo_full = parse_res.reading[GW-1:0] * gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_adv) begin
      mid_valid_q <= end_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_adv && end_en) begin
      mid_status_q  <= parse_res.status;
      mid_reading_q <= parse_res.reading;
      prod_hi_q     <= parse_res.reading[RW-1:GW] * gain_q;
      prod_lo_q     <= prod_lo_full[2*GW-1:GW];
    end
  end

  assign scaled   = {1'b0, prod_hi_q} + (RW+1)'(prod_lo_q);
  assign over     = |scaled[RW:DW];
  assign mid_ok   = mid_status_q == srpd_pkg::STATUS_OK;
  assign new_code = !mid_ok ? last_code_q : (over ? srpd_pkg::DacMax : scaled[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_code_q <= '0;
    end else if (out_adv) begin
      out_valid_q <= mid_valid_q;
      if (mid_valid_q && mid_ok) begin
        last_code_q <= new_code;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && mid_valid_q) begin
      out_status_q  <= mid_status_q;
      out_reading_q <= mid_reading_q;
      out_code_q    <= new_code;
      out_sat_q     <= mid_ok && over;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign reading_o       = out_reading_q;
  assign dac_code_o      = out_code_q;
  assign dac_saturated_o = out_sat_q;

endmodule

`default_nettype wire
